// ===== src/gbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap pixel expander package
// Shared types, register indexes and font tables for the expander blocks.
// ----------------------------------------------------------------------------
package gbpe_pkg;

	localparam int SCREEN_WIDTH_DEF  = 240;
	localparam int SCREEN_HEIGHT_DEF = 240;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FONT_KIND  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd3;

	localparam logic [1:0] FONT_6X8   = 2'd0;
	localparam logic [1:0] FONT_6X12  = 2'd1;
	localparam logic [1:0] FONT_8X16  = 2'd2;
	localparam logic [1:0] FONT_12X24 = 2'd3;

	typedef struct packed {
		logic [1:0]  font_kind;
		logic        overlay;
		logic [15:0] background;
		logic [15:0] foreground;
	} cfg_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] pix_byte;
		logic [2:0] last_idx;
		logic       done;
	} job_t;

	function automatic logic [4:0] font_height(input logic [1:0] kind);
		logic [4:0] h;
		unique case (kind)
			FONT_6X8:   h = 5'd8;
			FONT_6X12:  h = 5'd12;
			FONT_8X16:  h = 5'd16;
			FONT_12X24: h = 5'd24;
			default:    h = 5'd16;
		endcase
		return h;
	endfunction

	function automatic logic [5:0] glyph_length(input logic [1:0] kind);
		logic [5:0] n;
		unique case (kind)
			FONT_6X8:   n = 6'd6;
			FONT_6X12:  n = 6'd12;
			FONT_8X16:  n = 6'd16;
			FONT_12X24: n = 6'd36;
			default:    n = 6'd16;
		endcase
		return n;
	endfunction

endpackage

// ===== src/glyph_bitmap_pixel_expander_unit.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap pixel expander
// Turns column-major font glyph bytes into a stream of pixel writes.
// ----------------------------------------------------------------------------
// Each byte accepted while a glyph is active gives between one and eight
// pixel words, emitted at one word per cycle by the pixel counter of the back
// end while the output is not stalled; a byte accepted after its glyph is done
// gives none. The front end takes a byte whenever the two-entry job queue has
// room; a byte waits in the queue and the back end registers its words.
// Configuration is taken in any cycle and must only change while the block is
// idle.
module glyph_bitmap_pixel_expander_unit #(
	parameter int SCREEN_WIDTH  = gbpe_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = gbpe_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// origin_x, origin_y, glyph_byte
	input  logic [gbpe_pkg::S_TDATA_W-1:0]   s_tdata,
	// start_glyph
	input  logic [0:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// pixel_x, pixel_y, pixel_color
	output logic [gbpe_pkg::M_TDATA_W-1:0]   m_tdata,
	// glyph_done
	output logic [0:0]                       m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gbpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbpe_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import gbpe_pkg::*;

	cfg_t        cfg_q;
	job_t        front_job, head_job;
	logic        front_valid, front_ready, head_valid, head_ready;
	logic [7:0]  pixel_x, pixel_y;
	logic [15:0] pixel_color;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.font_kind  <= FONT_8X16;
			cfg_q.overlay    <= 1'b0;
			cfg_q.background <= 16'h0000;
			cfg_q.foreground <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FONT_KIND:  cfg_q.font_kind  <= cfg_data[1:0];
				REG_OVERLAY:    cfg_q.overlay    <= cfg_data[0];
				REG_BACKGROUND: cfg_q.background <= cfg_data;
				REG_FOREGROUND: cfg_q.foreground <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	gbpe_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.start_glyph (s_tuser[0]),
		.origin_x    (s_tdata[7:0]),
		.origin_y    (s_tdata[15:8]),
		.glyph_byte  (s_tdata[23:16]),
		.font_kind   (cfg_q.font_kind),
		.job_valid   (front_valid),
		.job_ready   (front_ready),
		.job         (front_job)
	);

	gbpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_job),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_data   (head_job)
	);

	gbpe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (head_valid),
		.job_ready    (head_ready),
		.job          (head_job),
		.cfg          (cfg_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.last_of_byte (m_tlast),
		.glyph_done   (m_tuser[0])
	);

	assign m_tdata = {pixel_color, pixel_y, pixel_x};

endmodule

// ===== src/gbpe_front.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap pixel expander front end
// Accepts glyph bytes, tracks the glyph cursor and classifies each byte.
// ----------------------------------------------------------------------------
module gbpe_front #(
	parameter int SCREEN_WIDTH  = gbpe_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = gbpe_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            start_glyph,
	input  logic [7:0]      origin_x,
	input  logic [7:0]      origin_y,
	input  logic [7:0]      glyph_byte,
	input  logic [1:0]      font_kind,
	output logic            job_valid,
	input  logic            job_ready,
	output gbpe_pkg::job_t  job
);
	import gbpe_pkg::*;

	localparam logic [8:0] ScrW = 9'(SCREEN_WIDTH);
	localparam logic [8:0] ScrH = 9'(SCREEN_HEIGHT);

	logic [7:0] column_pos_q, row_pos_q, top_row_q;
	logic [5:0] bytes_done_q;
	logic       halted_q;

	logic [7:0] cur_x, cur_y, cur_top, rel, lim_f;
	logic [5:0] cur_bytes, bytes_next;
	logic [4:0] fh;
	logic [8:0] lim_h, end_y, rel_end, x_next;
	logic [3:0] n;
	logic       active, hit_h, col_end, done, in_fire;

	always_comb begin
		cur_x     = start_glyph ? origin_x : column_pos_q;
		cur_y     = start_glyph ? origin_y : row_pos_q;
		cur_top   = start_glyph ? origin_y : top_row_q;
		cur_bytes = start_glyph ? 6'd0 : bytes_done_q;
		active    = start_glyph || !halted_q;
		fh        = font_height(font_kind);
		rel       = cur_y - cur_top;

		if ({1'b0, cur_y} >= ScrH) begin
			lim_h = 9'd1;
		end else begin
			lim_h = ScrH - {1'b0, cur_y};
		end
		if (rel >= {3'b0, fh}) begin
			lim_f = 8'd1;
		end else begin
			lim_f = {3'b0, fh} - rel;
		end

		n = 4'd8;
		if (lim_f < 8'd8) begin
			n = lim_f[3:0];
		end
		if (lim_h < {5'b0, n}) begin
			n = lim_h[3:0];
		end

		end_y      = {1'b0, cur_y} + {5'b0, n};
		rel_end    = {1'b0, rel} + {5'b0, n};
		hit_h      = end_y >= ScrH;
		col_end    = !hit_h && (rel_end >= {4'b0, fh});
		x_next     = {1'b0, cur_x} + 9'd1;
		bytes_next = cur_bytes + 6'd1;
		done       = hit_h || (col_end && (x_next >= ScrW)) || (bytes_next >= glyph_length(font_kind));
	end

	assign in_ready  = job_ready;
	assign in_fire   = in_valid && in_ready;
	assign job_valid = in_valid && active;

	always_comb begin
		job.x        = cur_x;
		job.y        = cur_y;
		job.pix_byte = glyph_byte;
		job.last_idx = 3'(n - 4'd1);
		job.done     = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_pos_q <= '0;
			row_pos_q    <= '0;
			top_row_q    <= '0;
			bytes_done_q <= '0;
			halted_q     <= 1'b1;
		end else if (in_fire && active) begin
			column_pos_q <= col_end ? x_next[7:0] : cur_x;
			row_pos_q    <= col_end ? cur_top : end_y[7:0];
			top_row_q    <= cur_top;
			bytes_done_q <= bytes_next;
			halted_q     <= done;
		end
	end

endmodule

// ===== src/gbpe_queue.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap pixel expander job queue
// Two-entry queue that decouples byte classification from pixel output.
// ----------------------------------------------------------------------------
module gbpe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  gbpe_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output gbpe_pkg::job_t pop_data
);
	import gbpe_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/gbpe_back.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap pixel expander back end
// Expands one queued byte into pixel words, one per cycle while not stalled.
// ----------------------------------------------------------------------------
module gbpe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  gbpe_pkg::job_t job,
	input  gbpe_pkg::cfg_t cfg,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     pixel_x,
	output logic [7:0]     pixel_y,
	output logic [15:0]    pixel_color,
	output logic           last_of_byte,
	output logic           glyph_done
);
	import gbpe_pkg::*;

	logic [2:0]  pix_cnt_q;
	logic        out_valid_q;
	logic        load, is_last, pix_bit;
	logic [15:0] color;

	assign load      = !out_valid_q || out_ready;
	assign is_last   = pix_cnt_q == job.last_idx;
	assign job_ready = load && job_valid && is_last;
	assign pix_bit   = job.pix_byte[3'd7 - pix_cnt_q];
	assign out_valid = out_valid_q;

	always_comb begin
		if (pix_bit) begin
			color = cfg.foreground;
		end else if (cfg.overlay) begin
			color = ~cfg.foreground;
		end else begin
			color = cfg.background;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pix_cnt_q   <= '0;
		end else if (load) begin
			out_valid_q <= job_valid;
			if (job_valid) begin
				pix_cnt_q <= is_last ? 3'd0 : pix_cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && job_valid) begin
			pixel_x      <= job.x;
			pixel_y      <= job.y + {5'b0, pix_cnt_q};
			pixel_color  <= color;
			last_of_byte <= is_last;
			glyph_done   <= is_last && job.done;
		end
	end

endmodule

// ===== src/gbpe_checker.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap pixel expander checker
// Watches the output stream of the expander and is bound to its top level.
// ----------------------------------------------------------------------------
module gbpe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [gbpe_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic [0:0]                     m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Output word changed while stalled.");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("Glyph end flagged on a word that does not end its byte.");

	a_column_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid
			&& (m_tdata[7:0] == $past(m_tdata[7:0]))
			&& (m_tdata[15:8] == 8'($past(m_tdata[15:8]) + 8'd1)))
		else $error("Pixels of one byte do not run down a single column.");

endmodule

bind glyph_bitmap_pixel_expander_unit gbpe_checker u_gbpe_checker (.*);
